FILE: rtl/core/pps_pkg.sv
// shared types and constants for the timer prescaler and period search
package pps_pkg;

    localparam int FREQ_W    = 32;
    localparam int VAL_W     = 16;
    localparam int RATIO_W   = 17;
    localparam int DIVISOR_W = 49;
    localparam int CNT_W     = 5;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [FREQ_W-1:0] TIMER_CLOCK_RESET = 32'd72000000;
    localparam logic [CNT_W-1:0]  DIV_LAST_STEP     = 5'd31;
    localparam logic              REG_TIMER_CLOCK   = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_DIV1,
        S_MUL2,
        S_DIV2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_first;
        logic mul_second;
        logic div_step;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_sts;

endpackage

FILE: rtl/core/pwm_prescaler_period_search.sv
// top level: timer prescaler and period search with register port and output register
//
// input channel: i_in_valid / o_in_stall carry one requested frequency per item
// output channel: o_out_valid / i_out_stall carry prescaler, period and found
// the timer clock register sits at byte address 0 of the register port
// each item runs from acceptance to a loaded result as one multiply and 32
// restoring divide steps for the divide ratio, one multiply and 32 steps for
// the period, then a load of the output register
// the single shared divider allows one item in flight at a time, accepted
// only while the controller is idle, after the last item has been loaded
// a finished result waits in the output register while the receiver stalls;
// the next item is still accepted and worked on, and it waits before its load
// until the output register is free
// reset clears the controller and output valid and sets the timer clock
// register to 72000000 hz; items are accepted from the first cycle after reset
module pwm_prescaler_period_search #(
    parameter int MAX_PRESCALE = 65535,
    parameter int PERIOD_LIMIT = 65535
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pps_pkg::ADDR_W-1:0]  paddr,
    input  logic [pps_pkg::DATA_W-1:0]  pwdata,
    output logic [pps_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [pps_pkg::FREQ_W-1:0]  i_target_freq,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [pps_pkg::VAL_W-1:0]   o_prescale_value,
    output logic [pps_pkg::VAL_W-1:0]   o_period_value,
    output logic                        o_found
);
    import pps_pkg::*;

    logic [FREQ_W-1:0] r_timer_clock;
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_prescale_value;
    logic [VAL_W-1:0]  r_period_value;
    logic              r_found;

    logic              w_reg_hit;
    logic              w_ready;
    logic              w_out_free;
    logic              w_out_load;
    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic [VAL_W-1:0]  w_prescale_value;
    logic [VAL_W-1:0]  w_period_value;
    logic              w_found;

    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[ADDR_W-1] == REG_TIMER_CLOCK);
    assign prdata    = w_reg_hit ? r_timer_clock : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_clock <= TIMER_CLOCK_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_timer_clock <= pwdata;
        end
    end

    assign o_in_stall = !w_ready;
    assign w_out_free = !r_out_valid || !i_out_stall;

    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_ready    (w_ready),
        .o_out_load (w_out_load),
        .o_cmd      (w_cmd)
    );

    pps_dpath #(
        .MAX_PRESCALE (MAX_PRESCALE),
        .PERIOD_LIMIT (PERIOD_LIMIT)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_target_freq    (i_target_freq),
        .i_timer_clock    (r_timer_clock),
        .o_sts            (w_sts),
        .o_prescale_value (w_prescale_value),
        .o_period_value   (w_period_value),
        .o_found          (w_found)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_prescale_value <= w_prescale_value;
            r_period_value   <= w_period_value;
            r_found          <= w_found;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_prescale_value = r_prescale_value;
    assign o_period_value   = r_period_value;
    assign o_found          = r_found;

endmodule

FILE: rtl/core/pps_dpath.sv
// datapath: multipliers, shared radix-2 divider and result fields
module pps_dpath #(
    parameter int MAX_PRESCALE = 65535,
    parameter int PERIOD_LIMIT = 65535
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pps_pkg::t_dp_cmd             i_cmd,
    input  logic [pps_pkg::FREQ_W-1:0]   i_target_freq,
    input  logic [pps_pkg::FREQ_W-1:0]   i_timer_clock,
    output pps_pkg::t_dp_sts             o_sts,
    output logic [pps_pkg::VAL_W-1:0]    o_prescale_value,
    output logic [pps_pkg::VAL_W-1:0]    o_period_value,
    output logic                         o_found
);
    import pps_pkg::*;

    localparam logic [VAL_W-1:0]  PER_LIM = VAL_W'(PERIOD_LIMIT);
    localparam logic [FREQ_W-1:0] PSC_MAX = FREQ_W'(MAX_PRESCALE);

    logic [FREQ_W-1:0]    r_freq;
    logic [DIVISOR_W-1:0] r_div;
    logic [FREQ_W-1:0]    r_rem;
    logic [FREQ_W-1:0]    r_quo;
    logic [CNT_W-1:0]     r_cnt;
    logic [VAL_W-1:0]     r_presc;
    logic                 r_ok;

    logic [FREQ_W:0]             w_trial;
    logic                        w_fits;
    logic [RATIO_W-1:0]          w_ratio;
    logic [VAL_W+FREQ_W-1:0]     w_prod_first;
    logic [RATIO_W+FREQ_W-1:0]   w_prod_second;

    assign w_trial = {r_rem, r_quo[FREQ_W-1]};
    assign w_fits  = {{(DIVISOR_W-FREQ_W-1){1'b0}}, w_trial} >= r_div;
    assign w_ratio = {1'b0, r_quo[VAL_W-1:0]} + RATIO_W'(1);

    assign w_prod_first  = PER_LIM * r_freq;
    assign w_prod_second = w_ratio * r_freq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ok  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_freq <= i_target_freq;
            end
            if (i_cmd.mul_first) begin
                r_div <= {{(DIVISOR_W-VAL_W-FREQ_W){1'b0}}, w_prod_first};
                r_rem <= '0;
                r_quo <= i_timer_clock;
                r_cnt <= '0;
            end
            if (i_cmd.mul_second) begin
                r_ok    <= (r_quo <= PSC_MAX);
                r_presc <= r_quo[VAL_W-1:0];
                r_div   <= w_prod_second;
                r_rem   <= '0;
                r_quo   <= i_timer_clock;
                r_cnt   <= '0;
            end
            if (i_cmd.div_step) begin
                if (w_fits) begin
                    r_rem <= FREQ_W'(w_trial - r_div[FREQ_W:0]);
                end else begin
                    r_rem <= w_trial[FREQ_W-1:0];
                end
                r_quo <= {r_quo[FREQ_W-2:0], w_fits};
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    assign o_sts.div_last  = (r_cnt == DIV_LAST_STEP);
    assign o_found          = r_ok && (r_quo != '0);
    assign o_prescale_value = o_found ? r_presc : '0;
    assign o_period_value   = o_found ? r_quo[VAL_W-1:0] : '0;

endmodule

FILE: rtl/core/pps_ctrl.sv
// controller: sequences the two multiply and divide passes of one item
module pps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_free,
    input  pps_pkg::t_dp_sts i_sts,
    output logic             o_ready,
    output logic             o_out_load,
    output pps_pkg::t_dp_cmd o_cmd
);
    import pps_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_MUL1;
            end
            S_MUL1: n_state = S_DIV1;
            S_DIV1: begin
                if (i_sts.div_last) n_state = S_MUL2;
            end
            S_MUL2: n_state = S_DIV2;
            S_DIV2: begin
                if (i_sts.div_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready          = 1'b0;
        o_out_load       = 1'b0;
        o_cmd.load       = 1'b0;
        o_cmd.mul_first  = 1'b0;
        o_cmd.mul_second = 1'b0;
        o_cmd.div_step   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_MUL1: o_cmd.mul_first = 1'b1;
            S_DIV1: o_cmd.div_step = 1'b1;
            S_MUL2: o_cmd.mul_second = 1'b1;
            S_DIV2: o_cmd.div_step = 1'b1;
            S_DONE: o_out_load = i_out_free;
            default: o_ready = 1'b0;
        endcase
    end

endmodule
